// File: sv/acap_pkg.sv
// ----------------------------------------------------------------------------
// ADC capture package
// Types and fixed constants shared by the capture front end, the command
// queue, the capture engine and the checker.
// ----------------------------------------------------------------------------
package acap_pkg;

   localparam int SAMPLE_W = 12;
   localparam int CHAN_W   = 3;
   localparam int BLEN_W   = 11;
   localparam int RCNT_W   = 7;
   localparam int FUNC_W   = 3;
   localparam int MIN_RING = 2;

   localparam logic [FUNC_W-1:0] FUNC_ONESHOT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_CONT    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_STOP    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_CONV    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd5;

   typedef enum logic [2:0] {
      OP_ONESHOT,
      OP_CONT,
      OP_STOP,
      OP_CONV,
      OP_READ,
      OP_CLEAR,
      OP_NONE
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_ONESHOT,
      MODE_CONT
   } mode_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_POP,
      BK_DATA
   } bk_state_type;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [CHAN_W-1:0]   channel;
      logic [SAMPLE_W-1:0] sample;
      logic [BLEN_W-1:0]   buffer_length;
      logic [RCNT_W-1:0]   read_count;
   } req_type;

   typedef struct packed {
      logic                accepted;
      logic [SAMPLE_W-1:0] sample_out;
      logic                sample_valid;
      logic                last;
      logic [RCNT_W-1:0]   copied_count;
      logic                idle;
      logic                overrun;
      logic [CHAN_W-1:0]   owner_channel;
   } rsp_type;

   typedef struct packed {
      op_type              op;
      logic                chan_ok;
      logic                len_ok;
      logic [CHAN_W-1:0]   channel;
      logic [SAMPLE_W-1:0] sample;
      logic [BLEN_W-1:0]   blen;
      logic [RCNT_W-1:0]   burst;
   } cmd_type;

endpackage

// File: sv/adc_sample_capture_fifo.sv
// ----------------------------------------------------------------------------
// ADC sample capture controller
// Channel lock with one-shot conversions and continuous capture into a ring
// buffer with sticky overrun, plus burst reads of the captured samples.
//
//   Channel  Ports                              Direction  Payload
//   request  req_valid, req_ready, req_data     in         req_type
//   result   rsp_valid, rsp_ready, rsp_data     out        rsp_type
//
// A request item other than a read passes the command queue entry and then
// the result register when the engine is free; a read's first sample passes
// the queue, the registered memory read in BK_POP and the result register in
// BK_DATA. The command queue holds two items meanwhile. A read burst loads
// each sample into the result register before the next memory read starts.
// Reset is synchronous and needs no clearing pass; the memory is unset.
// A stalled result holds the engine; the queue keeps taking items until full.
// ----------------------------------------------------------------------------
module adc_sample_capture_fifo
   import acap_pkg::*;
#(
   parameter int BUF_DEPTH    = 1024,
   parameter int MAX_BURST    = 64,
   parameter int NUM_CHANNELS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    fq_valid;
   logic    fq_ready;
   cmd_type fq_data;
   logic    qb_valid;
   logic    qb_ready;
   cmd_type qb_data;

   acap_front #(
      .BUF_DEPTH    (BUF_DEPTH),
      .MAX_BURST    (MAX_BURST),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (fq_valid),
      .cmd_ready (fq_ready),
      .cmd_data  (fq_data)
   );

   acap_cmd_q u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   acap_back #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (qb_valid),
      .cmd_ready (qb_ready),
      .cmd_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/acap_front.sv
// ----------------------------------------------------------------------------
// ADC capture front end
// Decodes each request item into a command, checks channel and ring length
// and limits the burst size to MAX_BURST before the command enters the queue.
// ----------------------------------------------------------------------------
module acap_front
   import acap_pkg::*;
#(
   parameter int BUF_DEPTH    = 1024,
   parameter int MAX_BURST    = 64,
   parameter int NUM_CHANNELS = 8
) (
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd_data
);

   always_comb begin
      cmd_data.op = OP_NONE;
      case (req_data.func)
         FUNC_ONESHOT: cmd_data.op = OP_ONESHOT;
         FUNC_CONT:    cmd_data.op = OP_CONT;
         FUNC_STOP:    cmd_data.op = OP_STOP;
         FUNC_CONV:    cmd_data.op = OP_CONV;
         FUNC_READ:    cmd_data.op = OP_READ;
         FUNC_CLEAR:   cmd_data.op = OP_CLEAR;
         default:      cmd_data.op = OP_NONE;
      endcase
      cmd_data.chan_ok = (32'(req_data.channel) < NUM_CHANNELS);
      cmd_data.len_ok  = (req_data.buffer_length >= BLEN_W'(MIN_RING)) &&
                         (32'(req_data.buffer_length) <= BUF_DEPTH);
      cmd_data.channel = req_data.channel;
      cmd_data.sample  = req_data.sample;
      cmd_data.blen    = req_data.buffer_length;
      cmd_data.burst   = (32'(req_data.read_count) > MAX_BURST) ?
                         RCNT_W'(MAX_BURST) : req_data.read_count;
   end

   assign cmd_valid = req_valid;
   assign req_ready = cmd_ready;

endmodule

// File: sv/acap_cmd_q.sv
// ----------------------------------------------------------------------------
// ADC capture command queue
// Two-entry queue that lets the front end keep taking items while the
// capture engine is busy with a read burst or a stalled result.
// ----------------------------------------------------------------------------
module acap_cmd_q
   import acap_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   localparam int QDEPTH = 2;

   cmd_type    entries_ff [QDEPTH];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   logic       pop;

   assign push_ready = (count_ff != 2'(QDEPTH));
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/acap_back.sv
// ----------------------------------------------------------------------------
// ADC capture engine
// Holds the channel lock, the ring positions and the sample memory, carries
// out one command at a time and drives the registered result channel.
// ----------------------------------------------------------------------------
module acap_back
   import acap_pkg::*;
#(
   parameter int BUF_DEPTH = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int RW = $clog2(BUF_DEPTH + 1);

   bk_state_type        state_ff;
   bk_state_type        state_in;
   mode_type            mode_ff;
   mode_type            mode_in;
   logic [CHAN_W-1:0]   active_chan_ff;
   logic [CHAN_W-1:0]   active_chan_in;
   logic                stop_pending_ff;
   logic                stop_pending_in;
   logic                store_enabled_ff;
   logic                store_enabled_in;
   logic [AW-1:0]       wr_pos_ff;
   logic [AW-1:0]       wr_pos_in;
   logic [AW-1:0]       rd_pos_ff;
   logic [AW-1:0]       rd_pos_in;
   logic [RW-1:0]       ring_size_ff;
   logic [RW-1:0]       ring_size_in;
   logic                overrun_ff;
   logic                overrun_in;
   logic [RCNT_W-1:0]   burst_ff;
   logic [RCNT_W-1:0]   burst_in;
   logic [RCNT_W-1:0]   got_ff;
   logic [RCNT_W-1:0]   got_in;
   logic                last_pend_ff;
   logic                last_pend_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   logic [SAMPLE_W-1:0] mem [BUF_DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                mem_we;
   logic                mem_re;
   logic                rsp_load;
   logic                out_free;
   logic                burst_done;
   logic [AW-1:0]       wr_next;

   function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p,
                                              input logic [RW-1:0] size);
      logic [RW:0] inc;
      inc = (RW+1)'(p) + 1'b1;
      return (inc >= {1'b0, size}) ? '0 : AW'(inc);
   endfunction

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign cmd_ready  = (state_ff == BK_IDLE) && out_free;
   assign burst_done = (got_ff == burst_ff) || (rd_pos_ff == wr_pos_ff) ||
                       (ring_size_ff == '0);
   assign wr_next    = next_pos(wr_pos_ff, ring_size_ff);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && out_free && cmd_data.op == OP_READ) begin
               state_in = BK_POP;
            end
         end
         BK_POP: begin
            if (!burst_done) begin
               state_in = BK_DATA;
            end else if (got_ff != '0 || out_free) begin
               state_in = BK_IDLE;
            end
         end
         BK_DATA: begin
            if (out_free) begin
               state_in = last_pend_ff ? BK_IDLE : BK_POP;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      mode_in          = mode_ff;
      active_chan_in   = active_chan_ff;
      stop_pending_in  = stop_pending_ff;
      store_enabled_in = store_enabled_ff;
      wr_pos_in        = wr_pos_ff;
      rd_pos_in        = rd_pos_ff;
      ring_size_in     = ring_size_ff;
      overrun_in       = overrun_ff;
      burst_in         = burst_ff;
      got_in           = got_ff;
      last_pend_in     = last_pend_ff;
      mem_we           = 1'b0;
      mem_re           = 1'b0;
      rsp_load         = 1'b0;
      rsp_in           = '0;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && out_free) begin
               if (cmd_data.op == OP_READ) begin
                  burst_in = cmd_data.burst;
                  got_in   = '0;
               end else begin
                  rsp_load    = 1'b1;
                  rsp_in.last = 1'b1;
                  case (cmd_data.op)
                     OP_ONESHOT: begin
                        if (mode_ff == MODE_IDLE && cmd_data.chan_ok) begin
                           mode_in         = MODE_ONESHOT;
                           active_chan_in  = cmd_data.channel;
                           stop_pending_in = 1'b1;
                           rsp_in.accepted = 1'b1;
                        end
                     end
                     OP_CONT: begin
                        if (mode_ff == MODE_IDLE && cmd_data.chan_ok &&
                            cmd_data.len_ok) begin
                           mode_in          = MODE_CONT;
                           active_chan_in   = cmd_data.channel;
                           store_enabled_in = 1'b1;
                           ring_size_in     = RW'(cmd_data.blen);
                           wr_pos_in        = '0;
                           rd_pos_in        = '0;
                           overrun_in       = 1'b0;
                           stop_pending_in  = 1'b0;
                           rsp_in.accepted  = 1'b1;
                        end
                     end
                     OP_STOP: begin
                        if (store_enabled_ff) begin
                           stop_pending_in = 1'b1;
                        end
                     end
                     OP_CONV: begin
                        if (mode_ff != MODE_IDLE &&
                            cmd_data.channel == active_chan_ff) begin
                           if (mode_ff == MODE_ONESHOT) begin
                              rsp_in.sample_out   = cmd_data.sample;
                              rsp_in.sample_valid = 1'b1;
                           end else if (!stop_pending_ff) begin
                              if (wr_next == rd_pos_ff) begin
                                 overrun_in = 1'b1;
                              end else begin
                                 mem_we    = 1'b1;
                                 wr_pos_in = wr_next;
                              end
                           end
                           if (stop_pending_ff) begin
                              stop_pending_in = 1'b0;
                              mode_in         = MODE_IDLE;
                           end
                        end
                     end
                     OP_CLEAR: overrun_in = 1'b0;
                     default: ;
                  endcase
               end
            end
         end
         BK_POP: begin
            if (!burst_done) begin
               mem_re       = 1'b1;
               rd_pos_in    = next_pos(rd_pos_ff, ring_size_ff);
               got_in       = got_ff + 1'b1;
               last_pend_in = (got_in == burst_ff) || (rd_pos_in == wr_pos_ff);
            end else if (got_ff == '0 && out_free) begin
               rsp_load    = 1'b1;
               rsp_in.last = 1'b1;
            end
         end
         BK_DATA: begin
            if (out_free) begin
               rsp_load            = 1'b1;
               rsp_in.sample_out   = rd_data_ff;
               rsp_in.sample_valid = 1'b1;
               rsp_in.copied_count = got_ff;
               rsp_in.last         = last_pend_ff;
            end
         end
         default: ;
      endcase
      rsp_in.idle          = (mode_in == MODE_IDLE);
      rsp_in.overrun       = overrun_in;
      rsp_in.owner_channel = (mode_in == MODE_IDLE) ? '0 : active_chan_in;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= BK_IDLE;
         mode_ff          <= MODE_IDLE;
         active_chan_ff   <= '0;
         stop_pending_ff  <= 1'b0;
         store_enabled_ff <= 1'b0;
         wr_pos_ff        <= '0;
         rd_pos_ff        <= '0;
         ring_size_ff     <= '0;
         overrun_ff       <= 1'b0;
         burst_ff         <= '0;
         got_ff           <= '0;
         last_pend_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         mode_ff          <= mode_in;
         active_chan_ff   <= active_chan_in;
         stop_pending_ff  <= stop_pending_in;
         store_enabled_ff <= store_enabled_in;
         wr_pos_ff        <= wr_pos_in;
         rd_pos_ff        <= rd_pos_in;
         ring_size_ff     <= ring_size_in;
         overrun_ff       <= overrun_in;
         burst_ff         <= burst_in;
         got_ff           <= got_in;
         last_pend_ff     <= last_pend_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_pos_ff] <= cmd_data.sample;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_pos_ff];
      end
   end

endmodule

// File: sv/acap_checker.sv
// ----------------------------------------------------------------------------
// ADC capture port checker
// Watches the top-level ports for request and result handshake and result field rules.
// ----------------------------------------------------------------------------
module acap_checker
   import acap_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request item changed or dropped while waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed or dropped while stalled");

   a_idle_owner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.idle |-> rsp_data.owner_channel == '0)
      else $error("owner channel reported while idle");

   a_no_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.sample_valid |->
         rsp_data.sample_out == '0 && rsp_data.copied_count == '0)
      else $error("sample data without a sample");

   a_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.accepted |->
         rsp_data.last && !rsp_data.idle && !rsp_data.sample_valid)
      else $error("accepted start item is malformed");

endmodule

bind adc_sample_capture_fifo acap_checker u_checker (.*);

// File: bench/acap_check_pkg.sv
// ----------------------------------------------------------------------------
// ADC capture scoreboard
// Keeps a cycle-free model of the capture controller. Every accepted request
// item is run through the model, and the result items it must produce are
// queued in order. Every result item taken from the block is compared, field
// by field, with the oldest queued one.
// ----------------------------------------------------------------------------
package acap_check_pkg;
   import acap_pkg::*;

   localparam int RING_DEPTH = 1024;
   localparam int BURST_MAX  = 64;

   class capture_checker;
      mode_type            mode;
      logic [CHAN_W-1:0]   owner;
      bit                  stop_pending;
      bit                  store_enabled;
      bit                  overrun;
      int unsigned         wr_pos;
      int unsigned         rd_pos;
      int unsigned         ring_len;
      logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
      rsp_type             due_rsps [$];
      int                  mismatches;

      function new();
         mode          = MODE_IDLE;
         owner         = '0;
         stop_pending  = 1'b0;
         store_enabled = 1'b0;
         overrun       = 1'b0;
         wr_pos        = 0;
         rd_pos        = 0;
         ring_len      = 0;
         mismatches    = 0;
      endfunction

      function int pending();
         return due_rsps.size();
      endfunction

      function int unsigned step_pos(int unsigned p);
         p++;
         if (p >= ring_len) begin
            p = 0;
         end
         return p;
      endfunction

      function void push_rsp(bit acc, logic [SAMPLE_W-1:0] smp, bit smp_valid,
                             bit last, int unsigned cnt);
         rsp_type e;
         e               = '0;
         e.accepted      = acc;
         e.sample_out    = smp;
         e.sample_valid  = smp_valid;
         e.last          = last;
         e.copied_count  = RCNT_W'(cnt);
         e.idle          = (mode == MODE_IDLE);
         e.overrun       = overrun;
         e.owner_channel = (mode == MODE_IDLE) ? '0 : owner;
         due_rsps.push_back(e);
      endfunction

      function string fmt_rsp(rsp_type r);
         return $sformatf("acc=%0d smp=%0d sv=%0d last=%0d cnt=%0d idle=%0d ovr=%0d own=%0d",
                          r.accepted, r.sample_out, r.sample_valid, r.last,
                          r.copied_count, r.idle, r.overrun, r.owner_channel);
      endfunction

      function void note_request(req_type r);
         bit                  acc;
         bit                  smp_valid;
         logic [SAMPLE_W-1:0] smp;
         int unsigned         nxt;
         int unsigned         limit;
         int unsigned         got;
         acc       = 1'b0;
         smp_valid = 1'b0;
         smp       = '0;
         case (r.func)
            FUNC_ONESHOT: begin
               if (mode == MODE_IDLE) begin
                  mode         = MODE_ONESHOT;
                  owner        = r.channel;
                  stop_pending = 1'b1;
                  acc          = 1'b1;
               end
            end
            FUNC_CONT: begin
               if (mode == MODE_IDLE && r.buffer_length >= MIN_RING &&
                   r.buffer_length <= RING_DEPTH) begin
                  mode          = MODE_CONT;
                  owner         = r.channel;
                  store_enabled = 1'b1;
                  ring_len      = r.buffer_length;
                  wr_pos        = 0;
                  rd_pos        = 0;
                  overrun       = 1'b0;
                  stop_pending  = 1'b0;
                  acc           = 1'b1;
               end
            end
            FUNC_STOP: begin
               if (store_enabled) begin
                  stop_pending = 1'b1;
               end
            end
            FUNC_CONV: begin
               if (mode != MODE_IDLE && r.channel == owner) begin
                  if (mode == MODE_ONESHOT) begin
                     smp       = r.sample;
                     smp_valid = 1'b1;
                  end else if (!stop_pending) begin
                     nxt = step_pos(wr_pos);
                     if (nxt == rd_pos) begin
                        overrun = 1'b1;
                     end else begin
                        ring_mem[wr_pos] = r.sample;
                        wr_pos           = nxt;
                     end
                  end
                  if (stop_pending) begin
                     stop_pending = 1'b0;
                     mode         = MODE_IDLE;
                  end
               end
            end
            FUNC_READ: begin
               limit = (r.read_count > BURST_MAX) ? BURST_MAX : r.read_count;
               got   = 0;
               while (got < limit && rd_pos != wr_pos && ring_len != 0) begin
                  smp    = ring_mem[rd_pos];
                  rd_pos = step_pos(rd_pos);
                  got++;
                  push_rsp(1'b0, smp, 1'b1, 1'b0, got);
               end
               if (got == 0) begin
                  push_rsp(1'b0, '0, 1'b0, 1'b1, 0);
               end else begin
                  due_rsps[$].last = 1'b1;
               end
               return;
            end
            FUNC_CLEAR: begin
               overrun = 1'b0;
            end
            default: begin
            end
         endcase
         push_rsp(acc, smp, smp_valid, 1'b1, 0);
      endfunction

      function void check_result(rsp_type act);
         rsp_type e;
         if (due_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: unexpected result item: %s", fmt_rsp(act));
            end
            return;
         end
         e = due_rsps.pop_front();
         if (act.accepted !== e.accepted || act.sample_out !== e.sample_out ||
             act.sample_valid !== e.sample_valid || act.last !== e.last ||
             act.copied_count !== e.copied_count || act.idle !== e.idle ||
             act.overrun !== e.overrun || act.owner_channel !== e.owner_channel) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: result mismatch\n  expected %s\n  actual   %s",
                        fmt_rsp(e), fmt_rsp(act));
            end
         end
      endfunction
   endclass

endpackage

// File: bench/adc_sample_capture_fifo_tb.sv
// ----------------------------------------------------------------------------
// ADC sample capture controller testbench
// Drives request items through the valid/ready handshake with random gaps,
// stalls the result channel at random, and checks every result item against
// the scoreboard model. A directed part covers the lock, rejected starts,
// one-shot results, overrun and burst limits; a random part runs capture
// sessions with random content mixed with noise.
// ----------------------------------------------------------------------------
module adc_sample_capture_fifo_tb;
   import acap_pkg::*;
   import acap_check_pkg::*;

   localparam int CYCLE_LIMIT  = 5000000;
   localparam int RANDOM_ITEMS = 300;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   capture_checker chk;
   int unsigned    cycle_count = 0;
   int unsigned    items_sent  = 0;

   adc_sample_capture_fifo DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic req_type mk(int unsigned f, int unsigned ch, int unsigned s,
                                  int unsigned bl, int unsigned rc);
      req_type it;
      it.func          = FUNC_W'(f);
      it.channel       = CHAN_W'(ch);
      it.sample        = SAMPLE_W'(s);
      it.buffer_length = BLEN_W'(bl);
      it.read_count    = RCNT_W'(rc);
      return it;
   endfunction

   function automatic int unsigned rnd_sample();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return 0;
      end else if (r == 1) begin
         return 4095;
      end
      return $urandom_range(0, 4095);
   endfunction

   function automatic int unsigned rnd_count();
      if ($urandom_range(0, 3) != 0) begin
         return $urandom_range(1, 8);
      end
      return $urandom_range(0, 127);
   endfunction

   task automatic send_item(input req_type item);
      int unsigned r;
      int unsigned gap;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      chk.note_request(item);
      items_sent++;
      r = $urandom_range(0, 19);
      if (r < 14) begin
         gap = 0;
      end else if (r < 19) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (chk.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic take_result();
      @(posedge clock);
      if (rsp_valid && rsp_ready) begin
         chk.check_result(rsp_data);
      end
   endtask

   initial begin
      int unsigned on_len;
      int unsigned off_len;
      do @(posedge clock); while (reset);
      forever begin
         on_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
         off_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(0, 3);
         rsp_ready <= 1'b1;
         repeat (on_len) take_result();
         if (off_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (off_len) take_result();
         end
      end
   end

   initial begin
      int unsigned base;
      int unsigned phase_mark;
      int unsigned pick;
      int unsigned ch;
      int unsigned len;
      chk = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(mk(FUNC_READ, 0, 0, 0, 0));
      send_item(mk(FUNC_READ, 7, 4095, 2047, 127));
      send_item(mk(FUNC_STOP, 0, 0, 0, 1));
      send_item(mk(FUNC_CONV, 2, 123, 0, 1));
      send_item(mk(FUNC_ONESHOT, 0, 0, 0, 1));
      send_item(mk(FUNC_ONESHOT, 7, 0, 0, 1));
      send_item(mk(FUNC_CONT, 7, 0, 16, 1));
      send_item(mk(FUNC_CONV, 5, 77, 0, 1));
      send_item(mk(FUNC_CONV, 0, 4095, 2047, 127));
      send_item(mk(FUNC_CONT, 1, 0, 0, 1));
      send_item(mk(FUNC_CONT, 1, 0, 1, 1));
      send_item(mk(FUNC_CONT, 1, 0, 1025, 1));
      send_item(mk(FUNC_CONT, 1, 0, 2047, 1));
      send_item(mk(FUNC_CONT, 7, 0, 2, 1));
      send_item(mk(FUNC_CONV, 7, 0, 0, 0));
      send_item(mk(FUNC_CONV, 7, 4095, 0, 0));
      send_item(mk(FUNC_READ, 7, 0, 0, 127));
      send_item(mk(FUNC_CLEAR, 0, 0, 0, 0));
      send_item(mk(FUNC_UNUSED_LO, 7, 4095, 2047, 127));
      send_item(mk(FUNC_UNUSED_HI, 0, 0, 0, 0));
      send_item(mk(FUNC_STOP, 0, 0, 0, 0));
      send_item(mk(FUNC_CONV, 7, 1234, 0, 0));
      send_item(mk(FUNC_ONESHOT, 4, 0, 0, 0));
      send_item(mk(FUNC_STOP, 0, 0, 0, 0));
      send_item(mk(FUNC_CONV, 4, 2730, 0, 0));
      send_item(mk(FUNC_CONT, 3, 0, 1024, 0));
      send_item(mk(FUNC_CONV, 3, 1365, 0, 0));
      send_item(mk(FUNC_READ, 0, 0, 0, 64));
      drain_results();

      base       = items_sent;
      phase_mark = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         if (chk.mode != MODE_IDLE) begin
            send_item(mk(FUNC_STOP, $urandom, $urandom, $urandom, $urandom));
            send_item(mk(FUNC_CONV, chk.owner, rnd_sample(), $urandom, $urandom));
         end
         pick = $urandom_range(0, 9);
         ch   = $urandom_range(0, 7);
         if (pick < 6) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               len = $urandom_range(2, 12);
            end else if (pick < 9) begin
               len = $urandom_range(13, 64);
            end else begin
               len = ($urandom_range(0, 1) != 0) ? 1024 : $urandom_range(65, 1023);
            end
            send_item(mk(FUNC_CONT, ch, $urandom, len, $urandom));
            repeat ($urandom_range(4, 24)) begin
               pick = $urandom_range(0, 19);
               if (pick < 10) begin
                  send_item(mk(FUNC_CONV, ch, rnd_sample(), $urandom, $urandom));
               end else if (pick < 12) begin
                  send_item(mk(FUNC_CONV, ch + $urandom_range(1, 7), rnd_sample(),
                               $urandom, $urandom));
               end else if (pick < 16) begin
                  send_item(mk(FUNC_READ, $urandom, $urandom, $urandom, rnd_count()));
               end else if (pick < 17) begin
                  send_item(mk(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom));
               end else if (pick < 18) begin
                  send_item(mk($urandom_range(FUNC_ONESHOT, FUNC_CONT), $urandom,
                               $urandom, $urandom_range(0, 2047), $urandom));
               end else if (pick < 19) begin
                  send_item(mk(FUNC_STOP, $urandom, $urandom, $urandom, $urandom));
               end else begin
                  send_item(mk($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI), $urandom,
                               $urandom, $urandom, $urandom));
               end
            end
            if ($urandom_range(0, 3) != 0) begin
               send_item(mk(FUNC_READ, $urandom, $urandom, $urandom, 64));
            end
         end else if (pick < 8) begin
            send_item(mk(FUNC_ONESHOT, ch, $urandom, $urandom, $urandom));
            if ($urandom_range(0, 2) == 0) begin
               send_item(mk(FUNC_STOP, $urandom, $urandom, $urandom, $urandom));
            end
            if ($urandom_range(0, 2) == 0) begin
               send_item(mk(FUNC_CONV, ch + $urandom_range(1, 7), rnd_sample(),
                            $urandom, $urandom));
            end
            send_item(mk(FUNC_CONV, ch, rnd_sample(), $urandom, $urandom));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_item(mk($urandom_range(0, 7), $urandom, $urandom, $urandom,
                            $urandom));
            end
         end
         if (items_sent - phase_mark >= 60) begin
            drain_results();
            phase_mark = items_sent;
         end
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (chk.mismatches == 0 && chk.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
